/* design/rtsf_pkg.sv */
// Shared types, widths, codes and the output scaling function for the
// range-tagged sample FIFO. No dependencies.
package rtsf_pkg;

  localparam int DEFAULT_SAMPLE_DEPTH = 32;

  localparam int BYTE_W   = 8;
  localparam int AXIS_W   = 12;  // one axis after the divide by 16
  localparam int SAMPLE_W = 3 * AXIS_W;
  localparam int OUT_W    = 16;
  localparam int RANGE_W  = 2;
  localparam int FUNC_W   = 2;
  localparam int CFG_W    = 6;
  localparam int CFG_IDX_W = 2;

  typedef logic [FUNC_W-1:0]  func_t;
  typedef logic [RANGE_W-1:0] range_t;

  // Operation codes.
  localparam func_t FUNC_PUSH  = 2'd0;
  localparam func_t FUNC_RANGE = 2'd1;
  localparam func_t FUNC_READ  = 2'd2;
  localparam func_t FUNC_CLEAR = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FILL_LIMIT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIG_ENDIAN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_RANGE = 2'd2;

  // Range codes.
  localparam range_t RANGE_2G  = 2'd0;
  localparam range_t RANGE_4G  = 2'd1;
  localparam range_t RANGE_8G  = 2'd2;
  localparam range_t RANGE_16G = 2'd3;

  // Raw axis value to milli-g: times 1, 2, 4 or 12 depending on range.
  function automatic logic signed [OUT_W-1:0] scale_axis(
    input logic signed [AXIS_W-1:0] v,
    input range_t rng
  );
    logic signed [OUT_W-1:0] ext;
    logic signed [OUT_W-1:0] res;
    ext = OUT_W'(v);
    unique case (rng)
      RANGE_2G:  res = ext;
      RANGE_4G:  res = ext <<< 1;
      RANGE_8G:  res = ext <<< 2;
      RANGE_16G: res = (ext <<< 3) + (ext <<< 2);
      default:   res = ext;
    endcase
    return res;
  endfunction

endpackage

/* design/rtsf_if.sv */
// Request and response channel interfaces of the range-tagged sample FIFO.
// Depends on rtsf_pkg.
interface rtsf_req_if;
  logic                           valid;
  logic                           ready;
  logic [rtsf_pkg::FUNC_W-1:0]    func;
  logic [rtsf_pkg::BYTE_W-1:0]    byte_0;
  logic [rtsf_pkg::BYTE_W-1:0]    byte_1;
  logic [rtsf_pkg::BYTE_W-1:0]    byte_2;
  logic [rtsf_pkg::BYTE_W-1:0]    byte_3;
  logic [rtsf_pkg::BYTE_W-1:0]    byte_4;
  logic [rtsf_pkg::BYTE_W-1:0]    byte_5;
  logic [rtsf_pkg::RANGE_W-1:0]   new_range;

  modport source (output valid, func, byte_0, byte_1, byte_2, byte_3, byte_4, byte_5,
                  new_range, input ready);
  modport sink   (input valid, func, byte_0, byte_1, byte_2, byte_3, byte_4, byte_5,
                  new_range, output ready);
endinterface

interface rtsf_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [rtsf_pkg::OUT_W-1:0]   x_milli_g;
  logic signed [rtsf_pkg::OUT_W-1:0]   y_milli_g;
  logic signed [rtsf_pkg::OUT_W-1:0]   z_milli_g;
  logic                                was_empty;
  logic [rtsf_pkg::RANGE_W-1:0]        range_used;

  modport source (output valid, x_milli_g, y_milli_g, z_milli_g, was_empty, range_used,
                  input ready);
  modport sink   (input valid, x_milli_g, y_milli_g, z_milli_g, was_empty, range_used,
                  output ready);
endinterface

/* design/rtsf_unpack.sv */
// Byte-pair unpacking of one sample: endian select and divide by 16 toward zero.
// Depends on rtsf_pkg.
module rtsf_unpack (
  input  logic                              big_endian,
  input  logic [rtsf_pkg::BYTE_W-1:0]       byte_0,
  input  logic [rtsf_pkg::BYTE_W-1:0]       byte_1,
  input  logic [rtsf_pkg::BYTE_W-1:0]       byte_2,
  input  logic [rtsf_pkg::BYTE_W-1:0]       byte_3,
  input  logic [rtsf_pkg::BYTE_W-1:0]       byte_4,
  input  logic [rtsf_pkg::BYTE_W-1:0]       byte_5,
  output logic [rtsf_pkg::SAMPLE_W-1:0]     sample
);

  logic [rtsf_pkg::BYTE_W-1:0] first  [3];
  logic [rtsf_pkg::BYTE_W-1:0] second [3];

  assign first[0]  = byte_0;
  assign second[0] = byte_1;
  assign first[1]  = byte_2;
  assign second[1] = byte_3;
  assign first[2]  = byte_4;
  assign second[2] = byte_5;

  always_comb begin
    logic [15:0] raw;
    logic [15:0] biased;
    sample = '0;
    for (int a = 0; a < 3; a++) begin
      raw = big_endian ? {first[a], second[a]} : {second[a], first[a]};
      // Negative values get a bias of 15 so the shift truncates toward zero.
      biased = raw + (raw[15] ? 16'd15 : 16'd0);
      sample[a*rtsf_pkg::AXIS_W +: rtsf_pkg::AXIS_W] = biased[15:4];
    end
  end

endmodule

/* design/range_tagged_sample_fifo.sv */
// Top level of the range-tagged sample FIFO: sequencer, sample memory and
// run-length range memory. Depends on rtsf_pkg, rtsf_if and rtsf_unpack.
//
// The block buffers three-axis acceleration samples, each tagged with the
// measuring range in force when it arrived, and hands them back in milli-g.
// Every request transaction is processed in a read-modify-write sequence over
// two memories with registered read ports: the sample memory and the run memory,
// which holds (range, count) runs. A transaction passes through an accept state
// and an update state, plus a second write state when a push drops the oldest
// sample while more than one run is live, because the run memory's single write
// port must then update both the oldest and the newest run. A read waits in its
// update state while the previous response transaction is still held on the
// response channel. After reset the block writes the first run entry in its init
// state before it accepts requests; configuration writes are taken in that state.
// Configuration is meant to be written while no request is in flight.
module range_tagged_sample_fifo #(
  parameter int SAMPLE_DEPTH = rtsf_pkg::DEFAULT_SAMPLE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [rtsf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rtsf_pkg::CFG_W-1:0]         cfg_data,
  rtsf_req_if.sink                           req,
  rtsf_rsp_if.source                         rsp
);

  localparam int RUN_DEPTH = SAMPLE_DEPTH + 1;
  localparam int SA_W      = $clog2(SAMPLE_DEPTH);
  localparam int CNT_W     = $clog2(SAMPLE_DEPTH + 1);
  localparam int RA_W      = $clog2(RUN_DEPTH);
  localparam int RC_W      = $clog2(RUN_DEPTH + 1);
  localparam int RANGE_W   = rtsf_pkg::RANGE_W;
  localparam int RUN_W     = RANGE_W + CNT_W;
  localparam int AXIS_W    = rtsf_pkg::AXIS_W;

  // Sequencer states.
  localparam logic [2:0] ST_INIT = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_EXEC = 3'd2;
  localparam logic [2:0] ST_WB2  = 3'd3;

  logic [2:0] state;
  logic [2:0] state_next;

  // Configuration registers.
  logic [rtsf_pkg::CFG_W-1:0] fill_limit;
  logic                       big_endian;
  rtsf_pkg::range_t           initial_range;

  // Queue pointers.
  logic [SA_W-1:0]  sample_head;
  logic [CNT_W-1:0] sample_count;
  logic [RA_W-1:0]  run_head;
  logic [RC_W-1:0]  run_count;

  // Latched request.
  rtsf_pkg::func_t             func_q;
  logic [rtsf_pkg::BYTE_W-1:0] bytes_q [6];
  rtsf_pkg::range_t            new_range_q;

  // Output register.
  logic                                out_valid;
  logic signed [rtsf_pkg::OUT_W-1:0]   out_x;
  logic signed [rtsf_pkg::OUT_W-1:0]   out_y;
  logic signed [rtsf_pkg::OUT_W-1:0]   out_z;
  logic                                out_empty;
  rtsf_pkg::range_t                    out_range;

  // Forwarding of an initial_range write that lands on the accept edge.
  logic             cfg_fwd;
  rtsf_pkg::range_t cfg_fwd_range;

  // Memories and their registered read data.
  logic [rtsf_pkg::SAMPLE_W-1:0] sample_mem [SAMPLE_DEPTH];
  logic [RUN_W-1:0]              run_mem    [RUN_DEPTH];
  logic [rtsf_pkg::SAMPLE_W-1:0] sample_rd;
  logic [RUN_W-1:0]              head_rd;
  logic [RUN_W-1:0]              last_rd;

  logic                          sample_we;
  logic [rtsf_pkg::SAMPLE_W-1:0] sample_wdata;
  logic                          run_we;
  logic [RA_W-1:0]               run_waddr;
  logic [RUN_W-1:0]              run_wdata;

  logic accept;
  logic cfg_init_wr;
  logic out_block;
  logic out_load;

  // Address arithmetic.
  logic [SA_W+1:0] slot_sum;
  logic [SA_W+1:0] slot_wrap;
  logic [SA_W-1:0] sample_slot;
  logic [SA_W-1:0] sample_head_inc;
  logic [RA_W+1:0] last_sum;
  logic [RA_W+1:0] last_wrap;
  logic [RA_W-1:0] last_idx;
  logic [RA_W-1:0] last_inc;
  logic [RA_W-1:0] run_head_inc;

  // Decoded run entries.
  rtsf_pkg::range_t head_range;
  logic [CNT_W-1:0] head_len;
  logic [CNT_W-1:0] head_len_dec;
  rtsf_pkg::range_t last_range;
  logic [CNT_W-1:0] last_len;

  logic             limit_full;
  logic [CNT_W-1:0] limit;
  logic             drop;
  logic             open_run;
  logic             pop_removes;
  rtsf_pkg::range_t init_val;

  assign accept      = (state == ST_IDLE) && req.valid;
  assign req.ready   = (state == ST_IDLE);
  assign cfg_init_wr = cfg_we && (cfg_index == rtsf_pkg::REG_INITIAL_RANGE);
  assign out_block   = out_valid && !rsp.ready;
  // A read loads the output register once the previous response has gone.
  assign out_load    = (state == ST_EXEC) && (func_q == rtsf_pkg::FUNC_READ) && !out_block;

  assign rsp.valid      = out_valid;
  assign rsp.x_milli_g  = out_x;
  assign rsp.y_milli_g  = out_y;
  assign rsp.z_milli_g  = out_z;
  assign rsp.was_empty  = out_empty;
  assign rsp.range_used = out_range;

  // Write slot of a push: head plus count, modulo the depth. After a drop the
  // head moves up and the count down, so the slot is the same.
  assign slot_sum    = (SA_W+2)'(sample_head) + (SA_W+2)'(sample_count);
  assign slot_wrap   = (slot_sum >= (SA_W+2)'(SAMPLE_DEPTH)) ?
                       slot_sum - (SA_W+2)'(SAMPLE_DEPTH) : slot_sum;
  assign sample_slot = slot_wrap[SA_W-1:0];
  assign sample_head_inc = (sample_head == SA_W'(SAMPLE_DEPTH - 1)) ?
                           '0 : sample_head + SA_W'(1);

  // Newest run: head plus count minus one, modulo the run depth.
  assign last_sum  = (RA_W+2)'(run_head) + (RA_W+2)'(run_count) - (RA_W+2)'(1);
  assign last_wrap = (last_sum >= (RA_W+2)'(RUN_DEPTH)) ?
                     last_sum - (RA_W+2)'(RUN_DEPTH) : last_sum;
  assign last_idx  = last_wrap[RA_W-1:0];
  assign last_inc  = (last_idx == RA_W'(RUN_DEPTH - 1)) ? '0 : last_idx + RA_W'(1);
  assign run_head_inc = (run_head == RA_W'(RUN_DEPTH - 1)) ? '0 : run_head + RA_W'(1);

  // Run entries as read at accept, with a same-edge initial_range write
  // folded in.
  always_comb begin
    head_range = head_rd[RUN_W-1 -: RANGE_W];
    head_len   = head_rd[CNT_W-1:0];
    last_range = last_rd[RUN_W-1 -: RANGE_W];
    last_len   = last_rd[CNT_W-1:0];
    if (cfg_fwd) begin
      last_range = cfg_fwd_range;
      if (run_head == last_idx) begin
        head_range = cfg_fwd_range;
      end
    end
  end

  assign head_len_dec = head_len - CNT_W'(1);
  assign pop_removes  = (head_len == CNT_W'(1)) && (run_count > RC_W'(1));
  assign open_run     = (last_len != '0) && (run_count < RC_W'(RUN_DEPTH));

  // A fill limit of zero or above the depth means the whole store.
  assign limit_full = (fill_limit == '0) || (32'(fill_limit) > 32'(SAMPLE_DEPTH));
  assign limit      = limit_full ? CNT_W'(SAMPLE_DEPTH) : CNT_W'(fill_limit);
  assign drop       = (sample_count >= limit) && (sample_count != '0);

  assign init_val = cfg_init_wr ? cfg_data[RANGE_W-1:0] : initial_range;

  rtsf_unpack u_unpack (
    .big_endian (big_endian),
    .byte_0     (bytes_q[0]),
    .byte_1     (bytes_q[1]),
    .byte_2     (bytes_q[2]),
    .byte_3     (bytes_q[3]),
    .byte_4     (bytes_q[4]),
    .byte_5     (bytes_q[5]),
    .sample     (sample_wdata)
  );

  // Sequencer. A push that drops the oldest sample with more than one run
  // live needs a second write state (ST_WB2); a read holds while the response waits.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT: state_next = ST_IDLE;
      ST_IDLE: begin
        if (req.valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
        if ((func_q == rtsf_pkg::FUNC_PUSH) && drop && (run_count != RC_W'(1))) begin
          state_next = ST_WB2;
        end else if ((func_q == rtsf_pkg::FUNC_READ) && out_block) begin
          state_next = ST_EXEC;
        end
      end
      ST_WB2:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory write port selection.
  always_comb begin
    sample_we = 1'b0;
    run_we    = 1'b0;
    run_waddr = last_idx;
    run_wdata = '0;
    unique case (state)
      ST_INIT: begin
        run_we    = 1'b1;
        run_waddr = '0;
        run_wdata = {init_val, CNT_W'(0)};
      end
      ST_IDLE: begin
        // With no samples the single run follows the initial_range register.
        if (cfg_init_wr && (sample_count == '0)) begin
          run_we    = 1'b1;
          run_wdata = {cfg_data[RANGE_W-1:0], CNT_W'(0)};
        end
      end
      ST_EXEC: begin
        unique case (func_q)
          rtsf_pkg::FUNC_PUSH: begin
            sample_we = 1'b1;
            if (!drop) begin
              run_we    = 1'b1;
              run_wdata = {last_range, last_len + CNT_W'(1)};
            end else if (run_count != RC_W'(1)) begin
              // Oldest run loses one here; the newest gains one next cycle.
              run_we    = 1'b1;
              run_waddr = run_head;
              run_wdata = {head_range, head_len_dec};
            end
          end
          rtsf_pkg::FUNC_RANGE: begin
            run_we = 1'b1;
            if (open_run) begin
              run_waddr = last_inc;
              run_wdata = {new_range_q, CNT_W'(0)};
            end else begin
              run_wdata = {new_range_q, last_len};
            end
          end
          rtsf_pkg::FUNC_READ: begin
            if (!out_block && (sample_count != '0) && (head_len != '0)) begin
              run_we    = 1'b1;
              run_waddr = run_head;
              run_wdata = {head_range, head_len_dec};
            end
          end
          rtsf_pkg::FUNC_CLEAR: begin
            if (sample_count != '0) begin
              run_we    = 1'b1;
              run_waddr = '0;
              run_wdata = {last_range, CNT_W'(0)};
            end
          end
          default: begin
          end
        endcase
      end
      ST_WB2: begin
        run_we    = 1'b1;
        run_wdata = {last_range, last_len + CNT_W'(1)};
      end
      default: begin
      end
    endcase
  end

  // Sample memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (sample_we) begin
      sample_mem[sample_slot] <= sample_wdata;
    end
    if (accept) begin
      sample_rd <= sample_mem[sample_head];
    end
  end

  // Run memory: one write port, two registered read ports (oldest and newest).
  always_ff @(posedge clk) begin
    if (run_we) begin
      run_mem[run_waddr] <= run_wdata;
    end
    if (accept) begin
      head_rd <= run_mem[run_head];
      last_rd <= run_mem[last_idx];
    end
  end

  // Request latch and forwarding payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      func_q      <= req.func;
      bytes_q[0]  <= req.byte_0;
      bytes_q[1]  <= req.byte_1;
      bytes_q[2]  <= req.byte_2;
      bytes_q[3]  <= req.byte_3;
      bytes_q[4]  <= req.byte_4;
      bytes_q[5]  <= req.byte_5;
      new_range_q <= req.new_range;
    end
    if (cfg_we) begin
      cfg_fwd_range <= cfg_data[RANGE_W-1:0];
    end
  end

  // Control state, configuration and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_INIT;
      fill_limit    <= '0;
      big_endian    <= 1'b0;
      initial_range <= rtsf_pkg::RANGE_2G;
      sample_head   <= '0;
      sample_count  <= '0;
      run_head      <= '0;
      run_count     <= RC_W'(1);
      out_valid     <= 1'b0;
      cfg_fwd       <= 1'b0;
    end else begin
      state   <= state_next;
      cfg_fwd <= (state == ST_IDLE) && cfg_init_wr && (sample_count == '0);

      if (cfg_we) begin
        unique case (cfg_index)
          rtsf_pkg::REG_FILL_LIMIT:    fill_limit    <= cfg_data;
          rtsf_pkg::REG_BIG_ENDIAN:    big_endian    <= cfg_data[0];
          rtsf_pkg::REG_INITIAL_RANGE: initial_range <= cfg_data[RANGE_W-1:0];
          default: begin
          end
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end

      if (state == ST_EXEC) begin
        unique case (func_q)
          rtsf_pkg::FUNC_PUSH: begin
            if (drop) begin
              sample_head <= sample_head_inc;
              if (pop_removes) begin
                run_head  <= run_head_inc;
                run_count <= run_count - RC_W'(1);
              end
            end else begin
              sample_count <= sample_count + CNT_W'(1);
            end
          end
          rtsf_pkg::FUNC_RANGE: begin
            if (open_run) begin
              run_count <= run_count + RC_W'(1);
            end
          end
          rtsf_pkg::FUNC_READ: begin
            if (out_load) begin
              if (sample_count == '0) begin
                out_x     <= '0;
                out_y     <= '0;
                out_z     <= '0;
                out_empty <= 1'b1;
                out_range <= rtsf_pkg::RANGE_2G;
              end else begin
                out_x <= rtsf_pkg::scale_axis(sample_rd[0*AXIS_W +: AXIS_W], head_range);
                out_y <= rtsf_pkg::scale_axis(sample_rd[1*AXIS_W +: AXIS_W], head_range);
                out_z <= rtsf_pkg::scale_axis(sample_rd[2*AXIS_W +: AXIS_W], head_range);
                out_empty    <= 1'b0;
                out_range    <= head_range;
                sample_head  <= sample_head_inc;
                sample_count <= sample_count - CNT_W'(1);
                if (pop_removes) begin
                  run_head  <= run_head_inc;
                  run_count <= run_count - RC_W'(1);
                end
              end
            end
          end
          rtsf_pkg::FUNC_CLEAR: begin
            if (sample_count != '0) begin
              sample_head  <= '0;
              sample_count <= '0;
              run_head     <= '0;
              run_count    <= RC_W'(1);
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

/* tb/tb_range_tagged_sample_fifo.sv */
// Self-checking testbench for the range-tagged sample FIFO top level.
// Depends on rtsf_pkg, the rtsf_req_if / rtsf_rsp_if interfaces and the block itself.
`timescale 1ns / 1ps

module tb_range_tagged_sample_fifo;

  localparam int DEPTH         = rtsf_pkg::DEFAULT_SAMPLE_DEPTH;
  localparam int RUNS          = DEPTH + 1;
  localparam int CYCLE_LIMIT   = 400000;
  // A transaction passes at most through the accept, update and second write states
  // inside the block, so these idle cycles after the last response let a trailing push or clear land.
  localparam int SETTLE_CYCLES = 4;
  localparam int LONG_HOLD     = 400;

  localparam logic [rtsf_pkg::BYTE_W-1:0] BYTE_CORNERS [4] = '{8'h00, 8'h7F, 8'h80, 8'hFF};

  typedef logic signed [rtsf_pkg::AXIS_W-1:0] axis_t;

  // One request transaction plus the idle cycles the sender waits before offering it.
  typedef struct {
    rtsf_pkg::func_t                  op;
    logic [5:0][rtsf_pkg::BYTE_W-1:0] raw;
    rtsf_pkg::range_t                 rng;
    int unsigned                      gap;
  } cmd_t;

  // One response transaction as the block should present it.
  typedef struct packed {
    logic signed [rtsf_pkg::OUT_W-1:0] x;
    logic signed [rtsf_pkg::OUT_W-1:0] y;
    logic signed [rtsf_pkg::OUT_W-1:0] z;
    logic                              was_empty;
    rtsf_pkg::range_t                  range_used;
  } reading_t;

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [rtsf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rtsf_pkg::CFG_W-1:0]     cfg_data;

  rtsf_req_if req_ch ();
  rtsf_rsp_if rsp_ch ();

  range_tagged_sample_fifo dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .req      (req_ch.sink),
    .rsp      (rsp_ch.source)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the block: registers, sample memory and run-length memory.
  // ---------------------------------------------------------------------------
  logic [rtsf_pkg::CFG_W-1:0] fill_reg;
  logic                       endian_reg;
  rtsf_pkg::range_t           init_reg;

  axis_t  smp_x [DEPTH];
  axis_t  smp_y [DEPTH];
  axis_t  smp_z [DEPTH];
  int     smp_head;
  int     smp_total;

  rtsf_pkg::range_t run_rng [RUNS];
  int               run_len [RUNS];
  int               run_head;
  int               run_total;

  // Stimulus and scoreboard storage.
  cmd_t     cmd_queue [$];
  reading_t readings  [$];

  // Bookkeeping for the closing summary.
  int n_push, n_drop, n_range, n_read, n_empty_read, n_clear, n_settings;
  int max_fill, max_runs;
  int mismatches;
  int cycle_count;

  // Driver, monitor and hold-off state.
  cmd_t        cur_cmd;
  bit          cmd_loaded;
  int unsigned gap_left;
  reading_t    next_reading;
  reading_t    want;
  int unsigned stall_left;
  bit          rsp_idle_on;
  logic        long_hold_arm;
  logic        arm_q;
  int unsigned hold_left;

  function automatic int last_run();
    return (run_head + run_total - 1) % RUNS;
  endfunction

  // Two bytes to one signed 16-bit word, then divided by 16 toward zero.
  function automatic axis_t unpack_axis(input logic [rtsf_pkg::BYTE_W-1:0] first,
                                        input logic [rtsf_pkg::BYTE_W-1:0] second);
    logic [15:0] word;
    int          v;
    word = endian_reg ? {first, second} : {second, first};
    v = int'($signed(word));
    return axis_t'(v / 16);
  endfunction

  function automatic logic signed [rtsf_pkg::OUT_W-1:0] to_milli_g(input axis_t a,
                                                                  input rtsf_pkg::range_t g);
    int k;
    case (g)
      rtsf_pkg::RANGE_2G: k = 1;
      rtsf_pkg::RANGE_4G: k = 2;
      rtsf_pkg::RANGE_8G: k = 4;
      default:            k = 12;
    endcase
    return rtsf_pkg::OUT_W'(int'(a) * k);
  endfunction

  // Removes the oldest sample and returns the range of the run it belonged to.
  // The caller makes sure at least one sample is stored.
  function automatic rtsf_pkg::range_t pop_oldest(output axis_t ox, output axis_t oy,
                                                  output axis_t oz);
    rtsf_pkg::range_t g;
    g  = run_rng[run_head];
    ox = smp_x[smp_head];
    oy = smp_y[smp_head];
    oz = smp_z[smp_head];
    smp_head = (smp_head + 1) % DEPTH;
    smp_total--;
    if (run_len[run_head] > 0) begin
      run_len[run_head]--;
      // An emptied run is retired unless it is the only one left.
      if (run_len[run_head] == 0 && run_total > 1) begin
        run_head = (run_head + 1) % RUNS;
        run_total--;
      end
    end
    return g;
  endfunction

  function automatic void reset_shadow();
    fill_reg   = '0;
    endian_reg = 1'b0;
    init_reg   = rtsf_pkg::RANGE_2G;
    smp_head   = 0;
    smp_total  = 0;
    foreach (run_rng[i]) begin
      run_rng[i] = rtsf_pkg::RANGE_2G;
      run_len[i] = 0;
    end
    run_head   = 0;
    run_total  = 1;
    run_rng[0] = init_reg;
  endfunction

  // Applies one accepted request to the shadow copy. Returns 1 when the request
  // produces a response, which is then placed in r.
  function automatic bit step_shadow(input cmd_t c, output reading_t r);
    int               lim;
    int               slot;
    int               back;
    rtsf_pkg::range_t g;
    axis_t            ax, ay, az;
    r = '0;
    case (c.op)
      rtsf_pkg::FUNC_PUSH: begin
        n_push++;
        // A limit of zero, or one beyond the memory, means the whole memory.
        lim = (fill_reg == 0 || fill_reg > DEPTH) ? DEPTH : int'(fill_reg);
        if (smp_total >= lim && smp_total > 0) begin
          g = pop_oldest(ax, ay, az);
          n_drop++;
        end
        slot = (smp_head + smp_total) % DEPTH;
        smp_x[slot] = unpack_axis(c.raw[0], c.raw[1]);
        smp_y[slot] = unpack_axis(c.raw[2], c.raw[3]);
        smp_z[slot] = unpack_axis(c.raw[4], c.raw[5]);
        smp_total++;
        run_len[last_run()]++;
        if (smp_total > max_fill) max_fill = smp_total;
        return 1'b0;
      end
      rtsf_pkg::FUNC_RANGE: begin
        n_range++;
        back = last_run();
        // A new run is opened only when the newest run already holds samples;
        // otherwise the newest run simply takes the new range.
        if (run_len[back] > 0 && run_total < RUNS) begin
          run_total++;
          back = last_run();
          run_len[back] = 0;
        end
        run_rng[back] = c.rng;
        if (run_total > max_runs) max_runs = run_total;
        return 1'b0;
      end
      rtsf_pkg::FUNC_READ: begin
        n_read++;
        r.was_empty  = 1'b1;
        r.range_used = rtsf_pkg::RANGE_2G;
        if (smp_total > 0) begin
          g = pop_oldest(ax, ay, az);
          r.x          = to_milli_g(ax, g);
          r.y          = to_milli_g(ay, g);
          r.z          = to_milli_g(az, g);
          r.was_empty  = 1'b0;
          r.range_used = g;
        end else begin
          n_empty_read++;
        end
        return 1'b1;
      end
      rtsf_pkg::FUNC_CLEAR: begin
        n_clear++;
        // Clearing an empty buffer leaves everything as it is; otherwise only
        // the newest range survives, as a single empty run.
        if (smp_total > 0) begin
          g = run_rng[last_run()];
          smp_head   = 0;
          smp_total  = 0;
          run_head   = 0;
          run_total  = 1;
          run_rng[0] = g;
          run_len[0] = 0;
        end
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic int unsigned draw_wait();
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
  endfunction

  function automatic void note_mismatch(input string what,
                                        input logic [rtsf_pkg::OUT_W-1:0] exp_v,
                                        input logic [rtsf_pkg::OUT_W-1:0] got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] %s mismatch: expected %0d (0x%h), got %0d (0x%h)", $time, what,
               $signed(exp_v), exp_v, $signed(got_v), got_v);
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, cycle limit.
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d responses still outstanding",
               cycle_count, readings.size());
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Request driver. It takes the next transaction from cmd_queue, holds valid low
  // for the drawn number of idle cycles, then offers the transaction until the
  // block accepts it. The shadow copy is stepped at the accepting edge, so every
  // expected response is queued in request order.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      cmd_loaded = 1'b0;
      gap_left   = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        if (step_shadow(cur_cmd, next_reading)) readings = {readings, next_reading};
        cmd_loaded = 1'b0;
      end
      if (!cmd_loaded && cmd_queue.size() != 0) begin
        cur_cmd = cmd_queue[0];
        cmd_queue.delete(0);
        gap_left   = cur_cmd.gap;
        cmd_loaded = 1'b1;
      end
      // Valid gets exactly one assignment per edge, so back-to-back transactions
      // keep it high without a glitch.
      if (cmd_loaded && gap_left == 0) begin
        req_ch.valid     <= 1'b1;
        req_ch.func      <= cur_cmd.op;
        req_ch.byte_0    <= cur_cmd.raw[0];
        req_ch.byte_1    <= cur_cmd.raw[1];
        req_ch.byte_2    <= cur_cmd.raw[2];
        req_ch.byte_3    <= cur_cmd.raw[3];
        req_ch.byte_4    <= cur_cmd.raw[4];
        req_ch.byte_5    <= cur_cmd.raw[5];
        req_ch.new_range <= cur_cmd.rng;
      end else begin
        req_ch.valid <= 1'b0;
        if (cmd_loaded) gap_left--;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Long receiver hold-off. A rising edge on long_hold_arm loads hold_left from LONG_HOLD;
  // until it has counted down, the response channel is not drained, and with reads
  // still streaming in, the block has to stall its request channel.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      arm_q     <= 1'b0;
      hold_left <= 0;
    end else begin
      arm_q <= long_hold_arm;
      if (long_hold_arm && !arm_q) hold_left <= LONG_HOLD;
      else if (hold_left != 0)     hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Response monitor. Every accepted response is compared field by field with the
  // oldest expected reading; after each one a random stall may be drawn.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (readings.size() == 0) begin
          note_mismatch("unexpected response (none pending)", '0, rsp_ch.x_milli_g);
        end else begin
          want = readings[0];
          readings.delete(0);
          if (rsp_ch.x_milli_g !== want.x)
            note_mismatch("x_milli_g", want.x, rsp_ch.x_milli_g);
          if (rsp_ch.y_milli_g !== want.y)
            note_mismatch("y_milli_g", want.y, rsp_ch.y_milli_g);
          if (rsp_ch.z_milli_g !== want.z)
            note_mismatch("z_milli_g", want.z, rsp_ch.z_milli_g);
          if (rsp_ch.was_empty !== want.was_empty)
            note_mismatch("was_empty", rtsf_pkg::OUT_W'(want.was_empty),
                          rtsf_pkg::OUT_W'(rsp_ch.was_empty));
          if (rsp_ch.range_used !== want.range_used)
            note_mismatch("range_used", rtsf_pkg::OUT_W'(want.range_used),
                          rtsf_pkg::OUT_W'(rsp_ch.range_used));
        end
        stall_left = rsp_idle_on ? draw_wait() : 0;
      end else if (stall_left != 0) begin
        stall_left--;
      end
      rsp_ch.ready <= (stall_left == 0) && (hold_left == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Register writes are issued at a rising edge and take effect at the next one,
  // where the shadow registers follow. Only called while the block is idle.
  task automatic write_reg(input logic [rtsf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rtsf_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      rtsf_pkg::REG_FILL_LIMIT: fill_reg = val;
      rtsf_pkg::REG_BIG_ENDIAN: endian_reg = val[0];
      rtsf_pkg::REG_INITIAL_RANGE: begin
        init_reg = rtsf_pkg::range_t'(val);
        // With nothing stored, the single empty run picks up the new range at once.
        if (smp_total == 0) run_rng[last_run()] = init_reg;
      end
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [rtsf_pkg::CFG_W-1:0] fill, input logic big,
                          input rtsf_pkg::range_t init);
    write_reg(rtsf_pkg::REG_FILL_LIMIT, fill);
    write_reg(rtsf_pkg::REG_BIG_ENDIAN, rtsf_pkg::CFG_W'(big));
    write_reg(rtsf_pkg::REG_INITIAL_RANGE, rtsf_pkg::CFG_W'(init));
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // raw holds byte_0 in its low eight bits and byte_5 in its high eight bits.
  task automatic add_cmd(input rtsf_pkg::func_t op, input logic [47:0] raw,
                         input rtsf_pkg::range_t rg);
    cmd_t c;
    c.op  = op;
    c.raw = raw;
    c.rng = rg;
    c.gap = 0;
    cmd_queue = {cmd_queue, c};
  endtask

  // Queues n random transactions with the given percentages of pushes, range
  // changes and reads; the rest are clears. Bytes lean toward sign and range corners.
  task automatic queue_burst(input int n, input int push_pct, input int range_pct,
                             input int read_pct, input bit gaps);
    cmd_t c;
    int   pick;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < push_pct)                             c.op = rtsf_pkg::FUNC_PUSH;
      else if (pick < push_pct + range_pct)            c.op = rtsf_pkg::FUNC_RANGE;
      else if (pick < push_pct + range_pct + read_pct) c.op = rtsf_pkg::FUNC_READ;
      else                                             c.op = rtsf_pkg::FUNC_CLEAR;
      for (int i = 0; i < 6; i++) begin
        if ($urandom_range(0, 7) == 0) c.raw[i] = BYTE_CORNERS[$urandom_range(0, 3)];
        else                           c.raw[i] = rtsf_pkg::BYTE_W'($urandom);
      end
      c.rng = rtsf_pkg::range_t'($urandom_range(0, 3));
      c.gap = gaps ? draw_wait() : 0;
      cmd_queue = {cmd_queue, c};
    end
  endtask

  // Waits until every queued transaction has been accepted and every expected
  // response has arrived, then lets a trailing push or clear finish.
  task automatic wait_idle();
    while (cmd_queue.size() != 0 || cmd_loaded || req_ch.valid || readings.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = rtsf_pkg::REG_FILL_LIMIT;
    cfg_data         = '0;
    req_ch.valid     = 1'b0;
    req_ch.func      = rtsf_pkg::FUNC_PUSH;
    req_ch.byte_0    = '0;
    req_ch.byte_1    = '0;
    req_ch.byte_2    = '0;
    req_ch.byte_3    = '0;
    req_ch.byte_4    = '0;
    req_ch.byte_5    = '0;
    req_ch.new_range = rtsf_pkg::RANGE_2G;
    rsp_ch.ready     = 1'b0;
    rsp_idle_on      = 1'b0;
    long_hold_arm    = 1'b0;
    mismatches = 0;
    n_push = 0; n_drop = 0; n_range = 0; n_read = 0;
    n_empty_read = 0; n_clear = 0; n_settings = 0;
    max_fill = 0; max_runs = 1;
    reset_shadow();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part: a fill limit of three, so the drop path shows up quickly,
    // and 16 g as the starting range, written while the buffer is empty.
    // The range field of a push is ignored by the block; one push carries the
    // top code so that field sees both values of each bit.
    set_regs(rtsf_pkg::CFG_W'(3), 1'b0, rtsf_pkg::RANGE_16G);
    add_cmd(rtsf_pkg::FUNC_READ,  48'h0, rtsf_pkg::RANGE_2G);   // read with nothing stored
    add_cmd(rtsf_pkg::FUNC_CLEAR, 48'h0, rtsf_pkg::RANGE_2G);   // clear with nothing stored
    add_cmd(rtsf_pkg::FUNC_RANGE, 48'h0, rtsf_pkg::RANGE_4G);   // unused run takes the range
    // Most negative, most positive, -1.
    add_cmd(rtsf_pkg::FUNC_PUSH,  48'hFFFF_7FFF_8000, rtsf_pkg::RANGE_2G);
    add_cmd(rtsf_pkg::FUNC_RANGE, 48'h0, rtsf_pkg::RANGE_16G);  // opens a second run
    // +16, +15, -16 around the divide.
    add_cmd(rtsf_pkg::FUNC_PUSH,  48'hFFF0_000F_0010, rtsf_pkg::RANGE_2G);
    add_cmd(rtsf_pkg::FUNC_RANGE, 48'h0, rtsf_pkg::RANGE_2G);
    add_cmd(rtsf_pkg::FUNC_RANGE, 48'h0, rtsf_pkg::RANGE_8G);   // overwrites the run just opened
    add_cmd(rtsf_pkg::FUNC_PUSH,  48'h0000_8001_FFF1, rtsf_pkg::RANGE_16G);
    // Limit reached: oldest dropped.
    add_cmd(rtsf_pkg::FUNC_PUSH,  48'h7F80_FF00_807F, rtsf_pkg::RANGE_2G);
    add_cmd(rtsf_pkg::FUNC_READ,  48'hFFFF_FFFF_FFFF, rtsf_pkg::RANGE_16G);
    add_cmd(rtsf_pkg::FUNC_READ,  48'h0, rtsf_pkg::RANGE_2G);
    add_cmd(rtsf_pkg::FUNC_READ,  48'h0, rtsf_pkg::RANGE_2G);
    add_cmd(rtsf_pkg::FUNC_READ,  48'h0, rtsf_pkg::RANGE_2G);   // buffer drained again
    add_cmd(rtsf_pkg::FUNC_RANGE, 48'h0, rtsf_pkg::RANGE_4G);   // the only run is empty
    add_cmd(rtsf_pkg::FUNC_PUSH,  48'h1234_5678_9ABC, rtsf_pkg::RANGE_2G);
    add_cmd(rtsf_pkg::FUNC_PUSH,  48'hEDCB_A987_6543, rtsf_pkg::RANGE_2G);
    add_cmd(rtsf_pkg::FUNC_CLEAR, 48'h0, rtsf_pkg::RANGE_2G);   // keeps only the 4 g range
    add_cmd(rtsf_pkg::FUNC_READ,  48'h0, rtsf_pkg::RANGE_2G);
    add_cmd(rtsf_pkg::FUNC_PUSH,  48'h7FFF_8000_0000, rtsf_pkg::RANGE_2G);
    add_cmd(rtsf_pkg::FUNC_READ,  48'h0, rtsf_pkg::RANGE_2G);
    add_cmd(rtsf_pkg::FUNC_PUSH,  48'hFF80_007F_FF00, rtsf_pkg::RANGE_2G);
    // Two samples stay behind.
    add_cmd(rtsf_pkg::FUNC_PUSH,  48'h8080_7F7F_0101, rtsf_pkg::RANGE_2G);
    wait_idle();

    // Whole memory as the limit, big-endian, and 8 g written while samples are
    // stored so it must not touch the runs. Full-rate traffic on both sides.
    set_regs(rtsf_pkg::CFG_W'(0), 1'b1, rtsf_pkg::RANGE_8G);
    queue_burst(60, 68, 22, 8, 1'b0);
    queue_burst(50, 15, 10, 72, 1'b0);
    wait_idle();

    // A limit of one: every push beyond the first replaces the stored sample.
    set_regs(rtsf_pkg::CFG_W'(1), 1'b0, rtsf_pkg::RANGE_2G);
    rsp_idle_on = 1'b1;
    queue_burst(30, 55, 25, 17, 1'b1);
    queue_burst(30, 30, 20, 47, 1'b1);
    wait_idle();

    // The largest register value, which acts as the whole memory. The receiver
    // holds off for a long stretch while reads keep arriving back to back.
    set_regs(rtsf_pkg::CFG_W'(63), 1'b1, rtsf_pkg::RANGE_4G);
    rsp_idle_on   = 1'b0;
    long_hold_arm <= 1'b1;
    queue_burst(50, 45, 5, 50, 1'b0);
    queue_burst(30, 40, 20, 38, 1'b1);
    wait_idle();
    long_hold_arm <= 1'b0;

    // A limit equal to the memory size, with range changes between most pushes
    // so that the run memory fills up.
    set_regs(rtsf_pkg::CFG_W'(DEPTH), 1'b0, rtsf_pkg::RANGE_16G);
    rsp_idle_on = 1'b1;
    queue_burst(50, 52, 45, 3, 1'b0);
    queue_burst(40, 20, 15, 63, 1'b1);
    wait_idle();

    // A random limit in between, random byte order and starting range.
    set_regs(rtsf_pkg::CFG_W'($urandom_range(2, DEPTH - 1)), 1'($urandom),
             rtsf_pkg::range_t'($urandom));
    queue_burst(40, 60, 25, 13, 1'b1);
    queue_burst(40, 25, 15, 58, 1'b1);
    wait_idle();

    $display("Covered %0d pushes (%0d dropped oldest), %0d range changes, %0d clears and",
             n_push, n_drop, n_range, n_clear);
    $display("%0d reads (%0d empty) over %0d register settings; peak fill %0d, peak runs %0d.",
             n_read, n_empty_read, n_settings, max_fill, max_runs);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
